// ----- rtl/md5_pkg.sv -----
`default_nettype none
package md5_pkg;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;

    typedef struct packed {
        logic       load_byte;
        logic [7:0] load_value;
        logic [5:0] load_pos;
        logic       start_round;
        logic       do_round;
        logic [5:0] round_idx;
        logic       finish_block;
        logic       clear_all;
    } t_cmd;

    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_shift(input logic [3:0] s);
        logic [4:0] v;
        case (s)
            4'd0: v = 5'd7;   4'd1: v = 5'd12;  4'd2: v = 5'd17;  4'd3: v = 5'd22;
            4'd4: v = 5'd5;   4'd5: v = 5'd9;   4'd6: v = 5'd14;  4'd7: v = 5'd20;
            4'd8: v = 5'd4;   4'd9: v = 5'd11;  4'd10: v = 5'd16; 4'd11: v = 5'd23;
            4'd12: v = 5'd6;  4'd13: v = 5'd10; 4'd14: v = 5'd15; default: v = 5'd21;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/md5_stream_hasher_top.sv -----
`default_nettype none
// MD5 stream engine: each input item carries an optional message byte and an end flag.
// Byte items are loaded one at a time; the 64th byte of a block starts the compression, one round
// per cycle, and no new item is taken until it ends. An end flag pads byte by byte (up to
// the end of the block, plus a second block when the length does not fit) and compresses,
// then four digest words go out, word 0 first.
module md5_stream_hasher_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // data_byte
    input  wire logic        s_axis_tlast,  // end_of_message
    input  wire logic        s_axis_tuser,  // has_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // digest_word
    output logic             m_axis_tlast,  // last_word
    output logic [1:0]       m_axis_tuser   // word_index
);

    md5_pkg::t_cmd cmd;
    logic [1:0]    word_sel;

    md5_control u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_has_byte  (s_axis_tuser),
        .i_data_byte (s_axis_tdata),
        .i_end       (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_word_sel  (word_sel),
        .o_cmd       (cmd)
    );

    md5_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_word_sel   (word_sel),
        .o_chain_word (m_axis_tdata)
    );

    assign m_axis_tuser = word_sel;
    assign m_axis_tlast = (word_sel == 2'd3);

endmodule
`default_nettype wire

// ----- rtl/md5_datapath.sv -----
`default_nettype none
module md5_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire md5_pkg::t_cmd i_cmd,
    input  wire logic [1:0]    i_word_sel,
    output logic [31:0]        o_chain_word
);

    logic [31:0] r_block [16];
    logic [31:0] r_chain [4];
    logic [31:0] r_a, r_b, r_c, r_d;

    logic [1:0]  grp;
    logic [31:0] f;
    logic [3:0]  g;
    logic [5:0]  r5, r3, r7;
    logic [31:0] sum;
    logic [4:0]  sh;
    logic [31:0] rot;
    logic [3:0]  ww;
    logic [4:0]  bsh;

    assign grp = i_cmd.round_idx[5:4];
    assign r5  = 6'((i_cmd.round_idx << 2) + i_cmd.round_idx + 6'd1);
    assign r3  = 6'((i_cmd.round_idx << 1) + i_cmd.round_idx + 6'd5);
    assign r7  = 6'((i_cmd.round_idx << 3) - i_cmd.round_idx);

    always_comb begin
        case (grp)
            2'd0: begin
                f = (r_b & r_c) | (~r_b & r_d);
                g = i_cmd.round_idx[3:0];
            end
            2'd1: begin
                f = (r_b & r_d) | (r_c & ~r_d);
                g = r5[3:0];
            end
            2'd2: begin
                f = r_b ^ r_c ^ r_d;
                g = r3[3:0];
            end
            default: begin
                f = r_c ^ (r_b | ~r_d);
                g = r7[3:0];
            end
        endcase
    end

    assign sum = r_a + f + r_block[g] + md5_pkg::round_const(i_cmd.round_idx);
    assign sh  = md5_pkg::round_shift({grp, i_cmd.round_idx[1:0]});
    assign rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    assign ww  = i_cmd.load_pos[5:2];
    assign bsh = {i_cmd.load_pos[1:0], 3'b000};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            if (i_cmd.load_pos[1:0] == 2'd0) begin
                r_block[ww] <= {24'd0, i_cmd.load_value};
            end else begin
                r_block[ww] <= (r_block[ww] & ~(32'hFF << bsh))
                             | ({24'd0, i_cmd.load_value} << bsh);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_chain[0] <= md5_pkg::H0;
            r_chain[1] <= md5_pkg::H1;
            r_chain[2] <= md5_pkg::H2;
            r_chain[3] <= md5_pkg::H3;
        end else if (i_cmd.finish_block) begin
            r_chain[0] <= r_chain[0] + r_a;
            r_chain[1] <= r_chain[1] + r_b;
            r_chain[2] <= r_chain[2] + r_c;
            r_chain[3] <= r_chain[3] + r_d;
        end
        if (i_cmd.start_round) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (i_cmd.do_round) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= rot + r_b;
        end
    end

    assign o_chain_word = r_chain[i_word_sel];

endmodule
`default_nettype wire

// ----- rtl/md5_control.sv -----
`default_nettype none
module md5_control (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_has_byte,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_end,
    input  wire logic          i_out_ready,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_word_sel,
    output md5_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [63:0] r_len, n_len;
    logic [63:0] r_flen, n_flen;
    logic [5:0]  r_pos, n_pos;
    logic [5:0]  r_rnd, n_rnd;
    logic        r_pad, n_pad;
    logic        r_eom, n_eom;
    logic        r_second, n_second;
    logic [1:0]  r_word, n_word;
    logic [5:0]  bpos;
    logic        flen_late;
    logic [7:0]  pad_byte;
    logic [63:0] len_sh;

    assign bpos      = r_len[8:3];
    assign flen_late = (r_flen[8:3] >= 6'd56);
    assign len_sh    = r_flen >> {r_pos[2:0], 3'b000};

    always_comb begin
        if (!r_second && r_pos == r_flen[8:3]) begin
            pad_byte = 8'h80;
        end else if (r_pos >= 6'd56 && (r_second || !flen_late)) begin
            pad_byte = len_sh[7:0];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_flen   = r_flen;
        n_pos    = r_pos;
        n_rnd    = r_rnd;
        n_pad    = r_pad;
        n_eom    = r_eom;
        n_second = r_second;
        n_word   = r_word;
        o_cmd    = '0;
        o_cmd.round_idx = r_rnd;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_eom = i_end;
                    if (i_has_byte) begin
                        o_cmd.load_byte  = 1'b1;
                        o_cmd.load_value = i_data_byte;
                        o_cmd.load_pos   = bpos;
                        n_len = r_len + 64'd8;
                    end
                    if (i_has_byte && bpos == 6'd63) begin
                        n_state = S_START;
                        n_pad   = 1'b0;
                    end else if (i_end) begin
                        n_flen  = i_has_byte ? r_len + 64'd8 : r_len;
                        n_pos   = i_has_byte ? bpos + 6'd1 : bpos;
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.load_byte  = 1'b1;
                o_cmd.load_value = pad_byte;
                o_cmd.load_pos   = r_pos;
                n_pos = r_pos + 6'd1;
                if (r_pos == 6'd63) begin
                    n_pad   = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.start_round = 1'b1;
                n_rnd   = 6'd0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.do_round = 1'b1;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish_block = 1'b1;
                if (r_pad) begin
                    if (!r_second && flen_late) begin
                        n_second = 1'b1;
                        n_state  = S_PAD;
                    end else begin
                        n_second = 1'b0;
                        n_state  = S_OUT;
                    end
                end else if (r_eom) begin
                    n_flen  = r_len;
                    n_pos   = 6'd0;
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_word = r_word + 2'd1;
                    if (r_word == 2'd3) begin
                        o_cmd.clear_all = 1'b1;
                        n_len   = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_flen   <= '0;
            r_pos    <= '0;
            r_rnd    <= '0;
            r_pad    <= 1'b0;
            r_eom    <= 1'b0;
            r_second <= 1'b0;
            r_word   <= '0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_flen   <= n_flen;
            r_pos    <= n_pos;
            r_rnd    <= n_rnd;
            r_pad    <= n_pad;
            r_eom    <= n_eom;
            r_second <= n_second;
            r_word   <= n_word;
        end
    end

    assign o_word_sel = r_word;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("input taken outside idle");
    a_out_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && r_word != 2'd3) |=> o_out_valid)
        else $error("digest words interrupted");
    a_round_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START) |=> (r_state == S_ROUND && r_rnd == 6'd0))
        else $error("round counter not started");

endmodule
`default_nettype wire
